/* rtl/core/dfsmc_pkg.sv */
// Shared codes for the depth-first maze carver: request types, step
// directions, frame try counts and bit positions of a room word.
// No dependencies.
`default_nettype none

package dfsmc_pkg;

	// request codes on req_type
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_STEP  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// step directions
	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_UP    = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	// try counts of a frame: four directions, or freshly entered
	localparam logic [2:0] TRY_FULL  = 3'd4;
	localparam logic [2:0] TRY_FRESH = 3'd5;

	// room word layout in the map memory
	localparam int MAP_W     = 3;
	localparam int MAP_VIS   = 0;
	localparam int MAP_EAST  = 1;
	localparam int MAP_SOUTH = 2;

endpackage

`default_nettype wire

/* rtl/core/dfsmc_ram.sv */
// Simple dual-port synchronous RAM with per-bit write enables and a
// registered read port. No dependencies.
`default_nettype none

module dfsmc_ram #(
	parameter int W  = 3,
	parameter int AW = 9
) (
	input  wire logic          clk,
	input  wire logic [W-1:0]  we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [2**AW];

	// bit-masked write
	always_ff @(posedge clk) begin
		for (int b = 0; b < W; b++) begin
			if (we[b]) mem[waddr][b] <= wdata[b];
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/dfs_maze_carver_top.sv */
// Depth-first maze carver: control sequencer over a room map memory and a
// walk stack memory. Depends on dfsmc_pkg and dfsmc_ram.
//
// Usage: drive req_type, rand_dir, cell_x, cell_y with start high; the beat
// is taken on a rising edge with start high and busy low. Every request
// gives exactly one result beat, shown for one cycle with result_valid high;
// the receiver cannot stall, so results are never held.
//   start (0):  clears the map with a sweep over all 2^(XW+YW) map words (512
//               at the default grid), then reports; busy through the sweep.
//   step  (1):  a fresh room first takes its offset; then each tried direction
//               reads the neighbor's map word, a direction off the grid needs
//               no read, each popped frame reads the stack, and a carve to the
//               right or down makes a second map write, to the current room.
//               Every room tries all four directions before it is popped; a
//               step when the walk is done only reports.
//   read  (2):  reads the map word; a cell off the grid or a wall corner is
//               answered without a map read, and unknown codes likewise.
// The rate is set by the single map read port: each neighbor test is a
// read and a compare, one after the other.
// Reset runs the same clearing sweep with busy high; the walk is then done and
// the stack empty.
`default_nettype none

module dfs_maze_carver_top
	import dfsmc_pkg::*;
#(
	parameter int ROOM_COLS = 32,
	parameter int ROOM_ROWS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] req_type,
	input  wire logic [1:0] rand_dir,
	input  wire logic [5:0] cell_x,
	input  wire logic [4:0] cell_y,
	output logic            busy,
	output logic            result_valid,
	output logic            carved_valid,
	output logic      [4:0] carved_x,
	output logic      [3:0] carved_y,
	output logic      [1:0] carved_from,
	output logic            done_res,
	output logic            cell_open
);

	localparam int XW         = $clog2(ROOM_COLS);
	localparam int YW         = $clog2(ROOM_ROWS);
	localparam int AW         = XW + YW;
	localparam int ROOM_COUNT = ROOM_COLS * ROOM_ROWS;
	localparam int DW         = $clog2(ROOM_COUNT + 1);
	localparam int SAW        = $clog2(ROOM_COUNT);
	localparam int FW         = XW + YW + 2 + 3;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_TRY, S_CHK, S_CUR, S_POP, S_READ
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic            clr_start_q;
	logic [1:0]      rdir_q;
	logic [DW-1:0]   depth_q;
	logic            done_q;
	logic [XW-1:0]   top_x_q;
	logic [YW-1:0]   top_y_q;
	logic [1:0]      top_d_q;
	logic [2:0]      top_tries_q;
	logic [AW-1:0]   nxt_q;
	logic [AW-1:0]   cur_q;
	logic [XW-1:0]   nx_q;
	logic [YW-1:0]   ny_q;
	logic [1:0]      j_q;
	logic [1:0]      rd_sel_q;

	logic            result_valid_q, carved_valid_q, done_res_q, cell_open_q;
	logic [4:0]      carved_x_q;
	logic [3:0]      carved_y_q;
	logic [1:0]      carved_from_q;

	// memory ports
	logic [MAP_W-1:0] map_we, map_wdata, map_rdata;
	logic [AW-1:0]    map_waddr, map_raddr;
	logic             map_re;
	logic [FW-1:0]    stk_wdata, stk_rdata;
	logic [SAW-1:0]   stk_waddr, stk_raddr;
	logic             stk_we, stk_re;

	// request decode for reads
	logic [4:0]      rx;
	logic [3:0]      ry;
	logic            rd_in_grid;
	logic            rd_corner;
	logic [1:0]      rd_sel;
	logic [AW-1:0]   rd_addr;

	// neighbor of the top frame
	logic [2:0]      tries_m1;
	logic [1:0]      dir_j;
	logic            nb_ok;
	logic            top_spent;
	logic [XW-1:0]   nb_x;
	logic [YW-1:0]   nb_y;

	logic            accept;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// grid cell decode
	always_comb begin
		rx         = cell_x[5:1];
		ry         = cell_y[4:1];
		rd_in_grid = (32'(rx) < ROOM_COLS) && (32'(ry) < ROOM_ROWS);
		rd_corner  = cell_x[0] && cell_y[0];
		rd_addr    = {YW'(ry), XW'(rx)};
		if (cell_x[0])      rd_sel = 2'(MAP_EAST);
		else if (cell_y[0]) rd_sel = 2'(MAP_SOUTH);
		else                rd_sel = 2'(MAP_VIS);
	end

	// next direction to try and its neighbor
	always_comb begin
		tries_m1  = top_tries_q - 3'd1;
		dir_j     = top_d_q + tries_m1[1:0];
		top_spent = (top_tries_q == 3'd0) || (top_tries_q > TRY_FULL);
		nb_x      = top_x_q;
		nb_y      = top_y_q;
		case (dir_j)
			DIR_LEFT: begin
				nb_ok = (top_x_q != '0);
				nb_x  = top_x_q - XW'(1);
			end
			DIR_UP: begin
				nb_ok = (top_y_q != '0);
				nb_y  = top_y_q - YW'(1);
			end
			DIR_RIGHT: begin
				nb_ok = (top_x_q != XW'(ROOM_COLS - 1));
				nb_x  = top_x_q + XW'(1);
			end
			default: begin
				nb_ok = (top_y_q != YW'(ROOM_ROWS - 1));
				nb_y  = top_y_q + YW'(1);
			end
		endcase
	end

	// map memory port control
	always_comb begin
		map_we    = '0;
		map_waddr = clr_q;
		map_wdata = '0;
		map_re    = 1'b0;
		map_raddr = rd_addr;
		case (state_q)
			S_CLEAR: begin
				map_we    = '1;
				map_waddr = clr_q;
				map_wdata = (clr_start_q && clr_q == '0) ? MAP_W'(1) : '0;
			end
			S_CHK: begin
				if (!map_rdata[MAP_VIS]) begin
					map_we    = '1;
					map_waddr = nxt_q;
					map_wdata = '0;
					map_wdata[MAP_VIS]   = 1'b1;
					map_wdata[MAP_EAST]  = (j_q == DIR_LEFT);
					map_wdata[MAP_SOUTH] = (j_q == DIR_UP);
				end
			end
			S_CUR: begin
				map_waddr = cur_q;
				map_wdata = '1;
				if (j_q == DIR_RIGHT) map_we[MAP_EAST]  = 1'b1;
				else                  map_we[MAP_SOUTH] = 1'b1;
			end
			S_IDLE: begin
				map_re    = accept && req_type == REQ_READ && rd_in_grid && !rd_corner;
				map_raddr = rd_addr;
			end
			S_TRY: begin
				map_re    = !top_spent && nb_ok;
				map_raddr = {nb_y, nb_x};
			end
			default: ;
		endcase
	end

	// stack memory port control: push on carve, read below top on pop
	always_comb begin
		stk_we    = (state_q == S_CHK) && !map_rdata[MAP_VIS];
		stk_waddr = SAW'(depth_q - DW'(1));
		stk_wdata = {top_x_q, top_y_q, top_d_q, top_tries_q};
		stk_re    = (state_q == S_TRY) && top_spent && (depth_q != DW'(1));
		stk_raddr = SAW'(depth_q - DW'(2));
	end

	dfsmc_ram #(.W(MAP_W), .AW(AW)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	dfsmc_ram #(.W(FW), .AW(SAW)) u_stack_ram (
		.clk   (clk),
		.we    ({FW{stk_we}}),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// sequencer, walk registers and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			clr_start_q    <= 1'b0;
			rdir_q         <= '0;
			depth_q        <= '0;
			done_q         <= 1'b1;
			top_x_q        <= '0;
			top_y_q        <= '0;
			top_d_q        <= '0;
			top_tries_q    <= '0;
			nxt_q          <= '0;
			cur_q          <= '0;
			nx_q           <= '0;
			ny_q           <= '0;
			j_q            <= '0;
			rd_sel_q       <= '0;
			result_valid_q <= 1'b0;
			carved_valid_q <= 1'b0;
			carved_x_q     <= '0;
			carved_y_q     <= '0;
			carved_from_q  <= '0;
			done_res_q     <= 1'b0;
			cell_open_q    <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
						if (clr_start_q) begin
							top_x_q        <= '0;
							top_y_q        <= '0;
							top_d_q        <= rdir_q;
							top_tries_q    <= TRY_FULL;
							depth_q        <= DW'(1);
							done_q         <= 1'b0;
							result_valid_q <= 1'b1;
							carved_valid_q <= 1'b0;
							carved_x_q     <= '0;
							carved_y_q     <= '0;
							carved_from_q  <= '0;
							done_res_q     <= 1'b0;
							cell_open_q    <= 1'b0;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						carved_valid_q <= 1'b0;
						carved_x_q     <= '0;
						carved_y_q     <= '0;
						carved_from_q  <= '0;
						done_res_q     <= done_q;
						cell_open_q    <= 1'b0;
						case (req_type)
							REQ_START: begin
								state_q     <= S_CLEAR;
								clr_q       <= '0;
								clr_start_q <= 1'b1;
								rdir_q      <= rand_dir;
							end
							REQ_STEP: begin
								if (done_q) begin
									result_valid_q <= 1'b1;
								end else begin
									state_q <= S_TRY;
									if (top_tries_q == TRY_FRESH) begin
										top_d_q     <= rand_dir;
										top_tries_q <= TRY_FULL;
									end
								end
							end
							REQ_READ: begin
								if (rd_in_grid && !rd_corner) begin
									state_q  <= S_READ;
									rd_sel_q <= rd_sel;
								end else begin
									result_valid_q <= 1'b1;
								end
							end
							default: result_valid_q <= 1'b1;
						endcase
					end
				end
				S_READ: begin
					state_q        <= S_IDLE;
					result_valid_q <= 1'b1;
					cell_open_q    <= map_rdata[rd_sel_q];
				end
				S_TRY: begin
					if (top_spent) begin
						if (depth_q == DW'(1)) begin
							// last frame gone: walk finished
							depth_q        <= '0;
							done_q         <= 1'b1;
							state_q        <= S_IDLE;
							result_valid_q <= 1'b1;
							carved_valid_q <= 1'b0;
							carved_x_q     <= '0;
							carved_y_q     <= '0;
							carved_from_q  <= '0;
							done_res_q     <= 1'b1;
							cell_open_q    <= 1'b0;
						end else begin
							depth_q <= depth_q - DW'(1);
							state_q <= S_POP;
						end
					end else begin
						top_tries_q <= tries_m1;
						if (nb_ok) begin
							nxt_q   <= {nb_y, nb_x};
							cur_q   <= {top_y_q, top_x_q};
							nx_q    <= nb_x;
							ny_q    <= nb_y;
							j_q     <= dir_j;
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					if (map_rdata[MAP_VIS]) begin
						state_q <= S_TRY;
					end else begin
						// carve: push current frame, enter the new room
						depth_q        <= depth_q + DW'(1);
						top_x_q        <= nx_q;
						top_y_q        <= ny_q;
						top_d_q        <= '0;
						top_tries_q    <= TRY_FRESH;
						result_valid_q <= 1'b1;
						carved_valid_q <= 1'b1;
						carved_x_q     <= 5'(nx_q);
						carved_y_q     <= 4'(ny_q);
						carved_from_q  <= j_q;
						done_res_q     <= 1'b0;
						cell_open_q    <= 1'b0;
						if (j_q == DIR_RIGHT || j_q == DIR_DOWN) state_q <= S_CUR;
						else                                     state_q <= S_IDLE;
					end
				end
				S_CUR: state_q <= S_IDLE;
				S_POP: begin
					{top_x_q, top_y_q, top_d_q, top_tries_q} <= stk_rdata;
					state_q <= S_TRY;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign carved_valid = carved_valid_q;
	assign carved_x     = carved_x_q;
	assign carved_y     = carved_y_q;
	assign carved_from  = carved_from_q;
	assign done_res     = done_res_q;
	assign cell_open    = cell_open_q;

	// walk is done exactly when the stack is empty
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done_q == (depth_q == '0))
		else $error("walk done flag and stack depth disagree");

	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(depth_q) <= ROOM_COUNT)
		else $error("stack depth beyond room count");

	a_stk_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(stk_we && stk_re))
		else $error("stack push and pop in the same cycle");

	a_carve_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && carved_valid |-> !done_res && !cell_open)
		else $error("carve beat with done or open flag");

	a_cur_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CUR |-> result_valid_q && carved_valid_q && $past(state_q) == S_CHK)
		else $error("current room write without a carve");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for dfs_maze_carver_top: directed table, then random maze walks.
// Every beat is checked against a behavioral carver kept in this file, or against the table for typed rows.
// Depends on dfsmc_pkg and the RTL of dfs_maze_carver_top.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dfsmc_pkg::*;

	localparam int COLS  = 32;
	localparam int ROWS  = 16;
	localparam int ROOMS = COLS * ROWS;

	// request code the block must ignore
	localparam logic [1:0] REQ_BAD = 2'd3;

	localparam int RAND_ITEMS  = 650;
	localparam int STALL_LIMIT = 20000;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic       carved_valid;
		logic [4:0] carved_x;
		logic [3:0] carved_y;
		logic [1:0] carved_from;
		logic       done_res;
		logic       cell_open;
	} maze_beat_t;

	typedef struct packed {
		logic [4:0] x;
		logic [3:0] y;
		logic [1:0] d;
		logic [2:0] tries;
	} walk_frame_t;

	typedef struct {
		logic [1:0] req;
		logic [1:0] rdir;
		logic [5:0] cx;
		logic [4:0] cy;
		bit         typed;
		maze_beat_t want;
	} stim_row_t;

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       start    = 1'b0;
	logic [1:0] req_type = REQ_START;
	logic [1:0] rand_dir = 2'd0;
	logic [5:0] cell_x   = 6'd0;
	logic [4:0] cell_y   = 5'd0;
	logic       busy;
	logic       result_valid;
	logic       carved_valid;
	logic [4:0] carved_x;
	logic [3:0] carved_y;
	logic [1:0] carved_from;
	logic       done_res;
	logic       cell_open;

	dfs_maze_carver_top #(
		.ROOM_COLS(COLS),
		.ROOM_ROWS(ROWS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_type(req_type),
		.rand_dir(rand_dir),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.busy(busy),
		.result_valid(result_valid),
		.carved_valid(carved_valid),
		.carved_x(carved_x),
		.carved_y(carved_y),
		.carved_from(carved_from),
		.done_res(done_res),
		.cell_open(cell_open)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// carver state mirrored by the bench
	logic        vis_map   [ROOMS] = '{default: 1'b0};
	logic        east_map  [ROOMS] = '{default: 1'b0};
	logic        south_map [ROOMS] = '{default: 1'b0};
	walk_frame_t walk_stk  [ROOMS];
	int          walk_depth = 0;
	logic        walk_fin   = 1'b1;

	maze_beat_t pending_beats [$];
	stim_row_t  stim_table [$];
	int         err_cnt    = 0;
	int         stall_cnt  = 0;
	int         burst_left = 0;

	// advance the mirrored carver by one request, return the beat it gives
	function automatic maze_beat_t carve_predict(input logic [1:0] req, input logic [1:0] rdir,
			input logic [5:0] cx, input logic [4:0] cy);
		maze_beat_t res;
		logic       carved;
		logic [1:0] j;
		int         t, nx, ny, cur, nxt, rx, ry, idx;
		res    = '0;
		carved = 1'b0;
		case (req)
			REQ_START: begin
				for (int i = 0; i < ROOMS; i++) begin
					vis_map[i]   = 1'b0;
					east_map[i]  = 1'b0;
					south_map[i] = 1'b0;
				end
				vis_map[0]  = 1'b1;
				walk_stk[0] = '{x: 5'd0, y: 4'd0, d: rdir, tries: TRY_FULL};
				walk_depth  = 1;
				walk_fin    = 1'b0;
			end
			REQ_STEP: begin
				// a freshly entered room takes its offset now
				if (!walk_fin && walk_depth > 0 && walk_stk[walk_depth-1].tries == TRY_FRESH) begin
					walk_stk[walk_depth-1].d     = rdir;
					walk_stk[walk_depth-1].tries = TRY_FULL;
				end
				while (!walk_fin && !carved) begin
					t = walk_depth - 1;
					if (walk_depth == 0) begin
						walk_fin = 1'b1;
					end else if (walk_stk[t].tries == 3'd0 || walk_stk[t].tries > TRY_FULL) begin
						walk_depth--;
					end else begin
						walk_stk[t].tries = walk_stk[t].tries - 3'd1;
						j  = walk_stk[t].d + walk_stk[t].tries[1:0];
						nx = int'(walk_stk[t].x);
						ny = int'(walk_stk[t].y);
						case (j)
							DIR_LEFT:  nx--;
							DIR_UP:    ny--;
							DIR_RIGHT: nx++;
							default:   ny++;
						endcase
						if (nx >= 0 && nx < COLS && ny >= 0 && ny < ROWS &&
								!vis_map[ny*COLS+nx]) begin
							cur = int'(walk_stk[t].y) * COLS + int'(walk_stk[t].x);
							nxt = ny * COLS + nx;
							vis_map[nxt] = 1'b1;
							case (j)
								DIR_LEFT:  east_map[nxt]  = 1'b1;
								DIR_UP:    south_map[nxt] = 1'b1;
								DIR_RIGHT: east_map[cur]  = 1'b1;
								default:   south_map[cur] = 1'b1;
							endcase
							if (walk_depth < ROOMS) begin
								walk_stk[walk_depth] = '{x: 5'(nx), y: 4'(ny), d: 2'd0,
									tries: TRY_FRESH};
								walk_depth++;
							end
							res.carved_valid = 1'b1;
							res.carved_x     = 5'(nx);
							res.carved_y     = 4'(ny);
							res.carved_from  = j;
							carved           = 1'b1;
						end
					end
				end
			end
			REQ_READ: begin
				rx = int'(cx) >> 1;
				ry = int'(cy) >> 1;
				if (rx < COLS && ry < ROWS) begin
					idx = ry * COLS + rx;
					case ({cx[0], cy[0]})
						2'b00:   res.cell_open = vis_map[idx];
						2'b10:   res.cell_open = east_map[idx];
						2'b01:   res.cell_open = south_map[idx];
						default: res.cell_open = 1'b0;
					endcase
				end
			end
			default: ;
		endcase
		res.done_res = walk_fin;
		return res;
	endfunction

	function automatic stim_row_t stim_row(input logic [1:0] req, input logic [1:0] rdir,
			input logic [5:0] cx, input logic [4:0] cy, input bit typed,
			input logic done_v, input logic open_v);
		stim_row_t r;
		r.req            = req;
		r.rdir           = rdir;
		r.cx             = cx;
		r.cy             = cy;
		r.typed          = typed;
		r.want           = '0;
		r.want.done_res  = done_v;
		r.want.cell_open = open_v;
		return r;
	endfunction

	task automatic cmp_field(input string name, input int e, input int a);
		if (e != a) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
		end
	endtask

	// present one request beat, wait for the handshake, record what it must return
	task automatic send_beat(input logic [1:0] req, input logic [1:0] rdir,
			input logic [5:0] cx, input logic [4:0] cy, input bit typed, input maze_beat_t want);
		maze_beat_t pred;
		start    <= 1'b1;
		req_type <= req;
		rand_dir <= rdir;
		cell_x   <= cx;
		cell_y   <= cy;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = carve_predict(req, rdir, cx, cy);
		pending_beats.push_back(typed ? want : pred);
	endtask

	// bursts of back-to-back beats with random gaps between them
	task automatic pace();
		int g;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (g > 0) begin
				start <= 1'b0;
				repeat (g) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
		end
	endtask

	// hold off until every pending beat has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_beats.size() != 0) @(posedge clk);
	endtask

	// result monitor and idle counter
	always @(posedge clk) begin
		maze_beat_t got, want;
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				stall_cnt = 0;
			else
				stall_cnt++;
			if (result_valid) begin
				got = '{carved_valid, carved_x, carved_y, carved_from, done_res, cell_open};
				if (pending_beats.size() == 0) begin
					err_cnt++;
					$display("%0t: result beat with none pending, got %h", $time, got);
				end else begin
					want = pending_beats.pop_front();
					cmp_field("carved_valid", int'(want.carved_valid), int'(got.carved_valid));
					cmp_field("carved_x", int'(want.carved_x), int'(got.carved_x));
					cmp_field("carved_y", int'(want.carved_y), int'(got.carved_y));
					cmp_field("carved_from", int'(want.carved_from), int'(got.carved_from));
					cmp_field("done_res", int'(want.done_res), int'(got.done_res));
					cmp_field("cell_open", int'(want.cell_open), int'(got.cell_open));
				end
			end
		end
	end

	// watchdog on cycles with no beat moving either way
	initial begin
		wait (stall_cnt >= STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int         rand_cnt, phase, span, n, pick, extra;
		logic [1:0] rq;

		// idle step, reads and bad code after reset
		stim_table.push_back(stim_row(REQ_STEP, 2'd0, 6'd0, 5'd0, 1'b1, 1'b1, 1'b0));
		stim_table.push_back(stim_row(REQ_READ, 2'd0, 6'd0, 5'd0, 1'b1, 1'b1, 1'b0));
		stim_table.push_back(stim_row(REQ_READ, 2'd3, 6'd63, 5'd31, 1'b1, 1'b1, 1'b0));
		stim_table.push_back(stim_row(REQ_BAD, 2'd0, 6'd0, 5'd0, 1'b1, 1'b1, 1'b0));
		// first walk
		stim_table.push_back(stim_row(REQ_START, 2'd0, 6'd0, 5'd0, 1'b1, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_READ, 2'd0, 6'd0, 5'd0, 1'b1, 1'b0, 1'b1));
		stim_table.push_back(stim_row(REQ_STEP, 2'd0, 6'd0, 5'd0, 1'b0, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_STEP, 2'd1, 6'd0, 5'd0, 1'b0, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_STEP, 2'd2, 6'd0, 5'd0, 1'b0, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_STEP, 2'd3, 6'd0, 5'd0, 1'b0, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_READ, 2'd0, 6'd0, 5'd1, 1'b0, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_READ, 2'd0, 6'd1, 5'd0, 1'b0, 1'b0, 1'b0));
		// wall corner, east and south grid edges, bad code mid-walk
		stim_table.push_back(stim_row(REQ_READ, 2'd0, 6'd1, 5'd1, 1'b1, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_READ, 2'd0, 6'd63, 5'd0, 1'b1, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_READ, 2'd0, 6'd0, 5'd31, 1'b1, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_BAD, 2'd2, 6'd63, 5'd31, 1'b1, 1'b0, 1'b0));
		// restart mid-walk with other offsets
		stim_table.push_back(stim_row(REQ_START, 2'd3, 6'd42, 5'd21, 1'b1, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_STEP, 2'd3, 6'd0, 5'd0, 1'b0, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_STEP, 2'd2, 6'd0, 5'd0, 1'b0, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_STEP, 2'd1, 6'd0, 5'd0, 1'b0, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_READ, 2'd0, 6'd2, 5'd0, 1'b0, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_READ, 2'd0, 6'd0, 5'd2, 1'b0, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_START, 2'd1, 6'd21, 5'd10, 1'b1, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_STEP, 2'd1, 6'd0, 5'd0, 1'b0, 1'b0, 1'b0));
		stim_table.push_back(stim_row(REQ_READ, 2'd0, 6'd62, 5'd30, 1'b0, 1'b0, 1'b0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[k]) begin
			send_beat(stim_table[k].req, stim_table[k].rdir, stim_table[k].cx, stim_table[k].cy,
				stim_table[k].typed, stim_table[k].want);
			pace();
		end

		// random walks: the first runs to completion, later ones are cut short
		rand_cnt = 0;
		phase    = 0;
		while (rand_cnt < RAND_ITEMS) begin
			drain();
			send_beat(REQ_START, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
				5'($urandom_range(0, 31)), 1'b0, '0);
			rand_cnt++;
			pace();
			span  = $urandom_range(15, 80);
			n     = 0;
			extra = 0;
			while ((phase == 0) ? (extra < 3) : (n < span)) begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					rq = REQ_BAD;
				else if (pick < 5 && phase != 0)
					rq = REQ_START;
				else if (pick < 15)
					rq = REQ_READ;
				else
					rq = REQ_STEP;
				if (rq == REQ_STEP && walk_fin)
					extra++;
				send_beat(rq, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
					5'($urandom_range(0, 31)), 1'b0, '0);
				n++;
				rand_cnt++;
				pace();
			end
			phase++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_beats.size() != 0) begin
			err_cnt++;
			$display("%0t: %0d result beats never arrived", $time, pending_beats.size());
		end
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
